// ===== hw/rtl/ptd_pkg.sv =====
// Shared types, constants and the multiply microprogram of the point to triangle distance block.
// Used by every module under hw/rtl; depends on nothing.
package ptd_pkg;

	// wide working width for exact products, multiplier operand magnitude and digit size
	localparam int WW    = 208;
	localparam int MAGW  = 100;
	localparam int DIG   = 4;
	localparam int NDIG  = MAGW / DIG;
	localparam int MCW   = $clog2(NDIG + 1);
	localparam int DW    = 33;
	localparam int PCW   = 6;
	localparam int DIV_STEPS = 64;
	localparam int SQ_STEPS  = 32;
	localparam int CNTW  = $clog2(DIV_STEPS);
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(DIV_STEPS - 1);
	localparam logic [CNTW-1:0] SQ_LAST  = CNTW'(SQ_STEPS - 1);

	localparam logic [PCW-1:0] PC_MAIN = 6'd0;
	localparam logic [PCW-1:0] PC_E0   = 6'd24;
	localparam logic [PCW-1:0] PC_E1   = 6'd26;
	localparam logic [PCW-1:0] PC_E12  = 6'd28;
	localparam logic [PCW-1:0] PC_IN   = 6'd30;

	localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;

	typedef logic signed [WW-1:0] wide_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [31:0]   coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} cvec_t;

	typedef struct packed {
		cvec_t v0;
		cvec_t v1;
		cvec_t v2;
	} vtx_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic  go;
		wide_t a;
		wide_t b;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		wide_t prod;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		R_E0X, R_E0Y, R_E0Z, R_E1X, R_E1Y, R_E1Z, R_DX, R_DY, R_DZ,
		R_A00, R_A01, R_A11, R_B0, R_B1, R_C, R_DET, R_S, R_T,
		R_NX, R_NY, R_NZ, R_PR, R_NUM, R_TMP, R_DENOM, R_NUMER
	} wreg_t;

	typedef enum logic [1:0] {
		M_SET,
		M_ADD,
		M_SUB
	} mode_t;

	typedef struct packed {
		wreg_t dst;
		wreg_t a;
		wreg_t b;
		mode_t mode;
		logic  last;
	} uop_t;

	typedef enum logic [2:0] {
		F_V0, F_V1, F_V2, F_E0, F_E1, F_E12, F_IN
	} feat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_WAIT, ST_PREP, ST_CMP, ST_SEL,
		ST_DCHK, ST_OVF, ST_DIV, ST_SQRT
	} st_t;

	typedef struct packed {
		logic st_le;
		logic p1_le;
		logic q1_le;
		logic r3_gt;
		logic r3_ge;
		logic r5_gt;
		logic r5_ge;
		logic n_le;
		logic n_ge;
	} cmp_t;

	// take the low cw bits of a slot and sign-extend them
	function automatic coord_t ptd_coord(input logic [31:0] raw, input int unsigned cw);
		logic [31:0] sh;
		sh = raw << (32 - cw);
		return $signed(sh) >>> (32 - cw);
	endfunction

	function automatic uop_t mk(input wreg_t d, input wreg_t a, input wreg_t b,
			input mode_t m, input logic l);
		uop_t u;
		u.dst  = d;
		u.a    = a;
		u.b    = b;
		u.mode = m;
		u.last = l;
		return u;
	endfunction

	// products in order: dot products, det, s, t, then one program per edge feature and one for the interior
	function automatic uop_t ptd_uop(input logic [PCW-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(R_A00, R_E0X, R_E0X, M_SET, 1'b0);
			6'd1:  u = mk(R_A00, R_E0Y, R_E0Y, M_ADD, 1'b0);
			6'd2:  u = mk(R_A00, R_E0Z, R_E0Z, M_ADD, 1'b0);
			6'd3:  u = mk(R_A01, R_E0X, R_E1X, M_SET, 1'b0);
			6'd4:  u = mk(R_A01, R_E0Y, R_E1Y, M_ADD, 1'b0);
			6'd5:  u = mk(R_A01, R_E0Z, R_E1Z, M_ADD, 1'b0);
			6'd6:  u = mk(R_A11, R_E1X, R_E1X, M_SET, 1'b0);
			6'd7:  u = mk(R_A11, R_E1Y, R_E1Y, M_ADD, 1'b0);
			6'd8:  u = mk(R_A11, R_E1Z, R_E1Z, M_ADD, 1'b0);
			6'd9:  u = mk(R_B0, R_DX, R_E0X, M_SET, 1'b0);
			6'd10: u = mk(R_B0, R_DY, R_E0Y, M_ADD, 1'b0);
			6'd11: u = mk(R_B0, R_DZ, R_E0Z, M_ADD, 1'b0);
			6'd12: u = mk(R_B1, R_DX, R_E1X, M_SET, 1'b0);
			6'd13: u = mk(R_B1, R_DY, R_E1Y, M_ADD, 1'b0);
			6'd14: u = mk(R_B1, R_DZ, R_E1Z, M_ADD, 1'b0);
			6'd15: u = mk(R_C, R_DX, R_DX, M_SET, 1'b0);
			6'd16: u = mk(R_C, R_DY, R_DY, M_ADD, 1'b0);
			6'd17: u = mk(R_C, R_DZ, R_DZ, M_ADD, 1'b0);
			6'd18: u = mk(R_DET, R_A00, R_A11, M_SET, 1'b0);
			6'd19: u = mk(R_DET, R_A01, R_A01, M_SUB, 1'b0);
			6'd20: u = mk(R_S, R_A01, R_B1, M_SET, 1'b0);
			6'd21: u = mk(R_S, R_A11, R_B0, M_SUB, 1'b0);
			6'd22: u = mk(R_T, R_A01, R_B0, M_SET, 1'b0);
			6'd23: u = mk(R_T, R_A00, R_B1, M_SUB, 1'b1);
			6'd24: u = mk(R_NUM, R_C, R_A00, M_SET, 1'b0);
			6'd25: u = mk(R_NUM, R_B0, R_B0, M_SUB, 1'b1);
			6'd26: u = mk(R_NUM, R_C, R_A11, M_SET, 1'b0);
			6'd27: u = mk(R_NUM, R_B1, R_B1, M_SUB, 1'b1);
			6'd28: u = mk(R_NUM, R_TMP, R_DENOM, M_SET, 1'b0);
			6'd29: u = mk(R_NUM, R_NUMER, R_NUMER, M_SUB, 1'b1);
			6'd30: u = mk(R_NX, R_E0Y, R_E1Z, M_SET, 1'b0);
			6'd31: u = mk(R_NX, R_E0Z, R_E1Y, M_SUB, 1'b0);
			6'd32: u = mk(R_NY, R_E0Z, R_E1X, M_SET, 1'b0);
			6'd33: u = mk(R_NY, R_E0X, R_E1Z, M_SUB, 1'b0);
			6'd34: u = mk(R_NZ, R_E0X, R_E1Y, M_SET, 1'b0);
			6'd35: u = mk(R_NZ, R_E0Y, R_E1X, M_SUB, 1'b0);
			6'd36: u = mk(R_PR, R_NX, R_DX, M_SET, 1'b0);
			6'd37: u = mk(R_PR, R_NY, R_DY, M_ADD, 1'b0);
			6'd38: u = mk(R_PR, R_NZ, R_DZ, M_ADD, 1'b0);
			6'd39: u = mk(R_NUM, R_PR, R_PR, M_SET, 1'b1);
			default: u = mk(R_NUM, R_PR, R_PR, M_SET, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// ===== hw/rtl/ptd_queue.sv =====
// Short queue of point offsets between the front and the back.
// Depends on ptd_pkg for the entry and status types.
module ptd_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptd_pkg::dvec_t wdata,
	input  logic           pop,
	output ptd_pkg::dvec_t head,
	output ptd_pkg::qstat_t qst
);
	import ptd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dvec_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop) rd_q <= nxt(rd_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head      = mem_q[rd_q];
	assign qst.empty = (cnt_q == '0);
	assign qst.full  = (cnt_q == CW'(DEPTH));

endmodule

// ===== hw/rtl/ptd_front.sv =====
// Front end: accepts query points, trims coordinates and forms the offset V0 - Q.
// Depends on ptd_pkg; feeds ptd_queue.
module ptd_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic            start,
	output logic            busy,
	input  logic [31:0]     query_x,
	input  logic [31:0]     query_y,
	input  logic [31:0]     query_z,
	input  ptd_pkg::cvec_t  v0,
	input  ptd_pkg::qstat_t qst,
	output logic            push,
	output ptd_pkg::dvec_t  wdata
);
	import ptd_pkg::*;

	coord_t qx, qy, qz;

	always_comb begin
		qx = ptd_coord(query_x, COORD_WIDTH);
		qy = ptd_coord(query_y, COORD_WIDTH);
		qz = ptd_coord(query_z, COORD_WIDTH);
		wdata.x = {v0.x[31], v0.x} - {qx[31], qx};
		wdata.y = {v0.y[31], v0.y} - {qy[31], qy};
		wdata.z = {v0.z[31], v0.z} - {qz[31], qz};
	end

	assign busy = qst.full;
	assign push = start && !qst.full;

endmodule

// ===== hw/rtl/ptd_mul.sv =====
// Shared serial multiplier: exact signed product, one radix-16 digit per cycle.
// Depends on ptd_pkg for widths and request/response types.
module ptd_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  ptd_pkg::mul_req_t req,
	output ptd_pkg::mul_rsp_t rsp
);
	import ptd_pkg::*;

	logic [MAGW-1:0]   ma_q, mb_q;
	logic [2*MAGW-1:0] acc_q;
	logic              neg_q;
	logic [MCW-1:0]    cnt_q;
	logic              run_q, fin_q, done_q;
	wide_t             prod_q;

	wide_t             abs_a, abs_b, mag;
	logic [2*MAGW-1:0] pp;

	always_comb begin
		abs_a = req.a[WW-1] ? -req.a : req.a;
		abs_b = req.b[WW-1] ? -req.b : req.b;
		pp    = (2*MAGW)'(ma_q) * (2*MAGW)'(mb_q[MAGW-1 -: DIG]);
		mag   = {{(WW-2*MAGW){1'b0}}, acc_q};
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			ma_q  <= abs_a[MAGW-1:0];
			mb_q  <= abs_b[MAGW-1:0];
			neg_q <= req.a[WW-1] ^ req.b[WW-1];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= (acc_q << DIG) + pp;
			mb_q  <= mb_q << DIG;
		end
		if (fin_q) begin
			prod_q <= neg_q ? -mag : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= MCW'(NDIG);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MCW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

// ===== hw/rtl/ptd_back.sv =====
// Back end: sequences the products, picks the closest feature, divides and takes the root.
// Depends on ptd_pkg; drives ptd_mul and pops ptd_queue.
module ptd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ptd_pkg::vtx_t     vtx,
	input  ptd_pkg::dvec_t    head,
	input  ptd_pkg::qstat_t   qst,
	output logic              pop,
	output ptd_pkg::mul_req_t mreq,
	input  ptd_pkg::mul_rsp_t mrsp,
	output logic              done,
	output logic [31:0]       distance,
	output logic              zero_divisor
);
	import ptd_pkg::*;

	st_t              state_q, state_d;
	logic [PCW-1:0]   pc_q;
	logic             feat_ph_q;
	logic [CNTW-1:0]  cnt_q;
	logic             done_q;

	wide_t e0x_q, e0y_q, e0z_q, e1x_q, e1y_q, e1z_q, dx_q, dy_q, dz_q;
	wide_t a00_q, a01_q, a11_q, b0_q, b1_q, c_q, det_q, s_q, t_q;
	wide_t nx_q, ny_q, nz_q, pr_q, num_q, tmp_q, denom_q, numer_q;
	wide_t p0_q, p1_q, q0_q, q1_q, tv1_q, den_q;
	wide_t rem_q, dsh_q;
	logic [63:0] quo_q, x_q, res_q, bit_q;
	cmp_t        cmp_q;
	logic [31:0] dist_q;
	logic        flag_q;

	uop_t        uop;
	wide_t       cur, wb, num_abs, st_sum, d3, d5, dn;
	feat_t       feat;
	logic [PCW-1:0] feat_pc;
	logic        den_bad, big, div_ge, sq_ge;
	logic [63:0] sq_sum, res_nx;

	function automatic wide_t wx(input diff_t d);
		return {{(WW-DW){d[DW-1]}}, d};
	endfunction

	function automatic logic le0(input wide_t v);
		return v[WW-1] || (v == '0);
	endfunction

	function automatic wide_t rd(input wreg_t r);
		wide_t v;
		case (r)
			R_E0X:   v = e0x_q;
			R_E0Y:   v = e0y_q;
			R_E0Z:   v = e0z_q;
			R_E1X:   v = e1x_q;
			R_E1Y:   v = e1y_q;
			R_E1Z:   v = e1z_q;
			R_DX:    v = dx_q;
			R_DY:    v = dy_q;
			R_DZ:    v = dz_q;
			R_A00:   v = a00_q;
			R_A01:   v = a01_q;
			R_A11:   v = a11_q;
			R_B0:    v = b0_q;
			R_B1:    v = b1_q;
			R_C:     v = c_q;
			R_DET:   v = det_q;
			R_S:     v = s_q;
			R_T:     v = t_q;
			R_NX:    v = nx_q;
			R_NY:    v = ny_q;
			R_NZ:    v = nz_q;
			R_PR:    v = pr_q;
			R_NUM:   v = num_q;
			R_TMP:   v = tmp_q;
			R_DENOM: v = denom_q;
			R_NUMER: v = numer_q;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		uop    = ptd_uop(pc_q);
		cur    = rd(uop.dst);
		case (uop.mode)
			M_SET:   wb = mrsp.prod;
			M_ADD:   wb = cur + mrsp.prod;
			M_SUB:   wb = cur - mrsp.prod;
			default: wb = mrsp.prod;
		endcase
		st_sum  = s_q + t_q - det_q;
		d3      = p1_q - p0_q;
		d5      = q1_q - q0_q;
		dn      = numer_q - denom_q;
		num_abs = num_q[WW-1] ? -num_q : num_q;
		den_bad = le0(den_q);
		big     = $unsigned(rem_q) >= $unsigned(dsh_q << 1);
		div_ge  = $unsigned(rem_q) >= $unsigned(dsh_q);
		sq_sum  = res_q + bit_q;
		sq_ge   = x_q >= sq_sum;
		res_nx  = sq_ge ? (res_q >> 1) + bit_q : res_q >> 1;
	end

	// region selection
	always_comb begin
		if (cmp_q.st_le) begin
			if (s_q[WW-1]) begin
				if (t_q[WW-1] && b0_q[WW-1]) feat = cmp_q.q1_le ? F_V1 : F_E0;
				else if (!b1_q[WW-1])        feat = F_V0;
				else                         feat = cmp_q.p1_le ? F_V2 : F_E1;
			end else if (t_q[WW-1]) begin
				if (!b0_q[WW-1]) feat = F_V0;
				else             feat = cmp_q.q1_le ? F_V1 : F_E0;
			end else begin
				feat = F_IN;
			end
		end else if (s_q[WW-1]) begin
			if (cmp_q.r3_gt)       feat = cmp_q.r3_ge ? F_V1 : F_E12;
			else if (cmp_q.p1_le)  feat = F_V2;
			else if (!b1_q[WW-1])  feat = F_V0;
			else                   feat = F_E1;
		end else if (t_q[WW-1]) begin
			if (cmp_q.r5_gt)       feat = cmp_q.r5_ge ? F_V2 : F_E12;
			else if (cmp_q.q1_le)  feat = F_V1;
			else if (!b0_q[WW-1])  feat = F_V0;
			else                   feat = F_E0;
		end else begin
			if (cmp_q.n_le) feat = F_V2;
			else            feat = cmp_q.n_ge ? F_V1 : F_E12;
		end
		case (feat)
			F_E0:    feat_pc = PC_E0;
			F_E1:    feat_pc = PC_E1;
			F_E12:   feat_pc = PC_E12;
			F_IN:    feat_pc = PC_IN;
			default: feat_pc = PC_MAIN;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (!qst.empty) state_d = ST_MUL;
			ST_MUL:  state_d = ST_WAIT;
			ST_WAIT: begin
				if (mrsp.done) begin
					if (!uop.last)     state_d = ST_MUL;
					else if (feat_ph_q) state_d = ST_DCHK;
					else               state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_CMP;
			ST_CMP:  state_d = ST_SEL;
			ST_SEL:  state_d = (feat inside {F_V0, F_V1, F_V2}) ? ST_DCHK : ST_MUL;
			ST_DCHK: state_d = den_bad ? ST_IDLE : ST_OVF;
			ST_OVF:  state_d = big ? ST_IDLE : ST_DIV;
			ST_DIV:  if (cnt_q == DIV_LAST) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == SQ_LAST) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = (state_q == ST_IDLE) && !qst.empty;
		mreq.go = (state_q == ST_MUL);
		mreq.a  = rd(uop.a);
		mreq.b  = rd(uop.b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= PC_MAIN;
			feat_ph_q <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					pc_q      <= PC_MAIN;
					feat_ph_q <= 1'b0;
				end
				ST_WAIT: if (mrsp.done && !uop.last) pc_q <= pc_q + 1'b1;
				ST_SEL: begin
					pc_q      <= feat_pc;
					feat_ph_q <= 1'b1;
				end
				ST_DCHK: if (den_bad) done_q <= 1'b1;
				ST_OVF: begin
					cnt_q <= '0;
					if (big) done_q <= 1'b1;
				end
				ST_DIV: cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + 1'b1;
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQ_LAST) done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				e0x_q <= wx({vtx.v1.x[31], vtx.v1.x} - {vtx.v0.x[31], vtx.v0.x});
				e0y_q <= wx({vtx.v1.y[31], vtx.v1.y} - {vtx.v0.y[31], vtx.v0.y});
				e0z_q <= wx({vtx.v1.z[31], vtx.v1.z} - {vtx.v0.z[31], vtx.v0.z});
				e1x_q <= wx({vtx.v2.x[31], vtx.v2.x} - {vtx.v0.x[31], vtx.v0.x});
				e1y_q <= wx({vtx.v2.y[31], vtx.v2.y} - {vtx.v0.y[31], vtx.v0.y});
				e1z_q <= wx({vtx.v2.z[31], vtx.v2.z} - {vtx.v0.z[31], vtx.v0.z});
				dx_q  <= wx(head.x);
				dy_q  <= wx(head.y);
				dz_q  <= wx(head.z);
			end
			ST_WAIT: begin
				if (mrsp.done) begin
					case (uop.dst)
						R_A00:   a00_q <= wb;
						R_A01:   a01_q <= wb;
						R_A11:   a11_q <= wb;
						R_B0:    b0_q  <= wb;
						R_B1:    b1_q  <= wb;
						R_C:     c_q   <= wb;
						R_DET:   det_q <= wb;
						R_S:     s_q   <= wb;
						R_T:     t_q   <= wb;
						R_NX:    nx_q  <= wb;
						R_NY:    ny_q  <= wb;
						R_NZ:    nz_q  <= wb;
						R_PR:    pr_q  <= wb;
						R_NUM:   num_q <= wb;
						default: ;
					endcase
				end
			end
			ST_PREP: begin
				det_q   <= det_q[WW-1] ? -det_q : det_q;
				denom_q <= a00_q - (a01_q <<< 1) + a11_q;
				numer_q <= a11_q + b1_q - a01_q - b0_q;
				tmp_q   <= a11_q + (b1_q <<< 1) + c_q;
				tv1_q   <= a00_q + (b0_q <<< 1) + c_q;
				p0_q    <= a01_q + b0_q;
				p1_q    <= a11_q + b1_q;
				q0_q    <= a01_q + b1_q;
				q1_q    <= a00_q + b0_q;
			end
			ST_CMP: begin
				cmp_q.st_le <= le0(st_sum);
				cmp_q.p1_le <= le0(p1_q);
				cmp_q.q1_le <= le0(q1_q);
				cmp_q.r3_gt <= !le0(d3);
				cmp_q.r3_ge <= !((d3 - denom_q) < 0);
				cmp_q.r5_gt <= !le0(d5);
				cmp_q.r5_ge <= !((d5 - denom_q) < 0);
				cmp_q.n_le  <= le0(numer_q);
				cmp_q.n_ge  <= !dn[WW-1];
			end
			ST_SEL: begin
				case (feat)
					F_V0: begin
						num_q <= c_q;
						den_q <= wide_t'(1);
					end
					F_V1: begin
						num_q <= tv1_q;
						den_q <= wide_t'(1);
					end
					F_V2: begin
						num_q <= tmp_q;
						den_q <= wide_t'(1);
					end
					F_E0:    den_q <= a00_q;
					F_E1:    den_q <= a11_q;
					F_E12:   den_q <= denom_q;
					default: den_q <= det_q;
				endcase
			end
			ST_DCHK: begin
				rem_q  <= num_abs;
				dsh_q  <= den_q << (DIV_STEPS - 1);
				dist_q <= DIST_SAT;
				flag_q <= den_bad;
			end
			ST_OVF: begin
				dist_q <= DIST_SAT;
				flag_q <= 1'b0;
			end
			ST_DIV: begin
				if (div_ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[62:0], div_ge};
				dsh_q <= dsh_q >>> 1;
				if (cnt_q == DIV_LAST) begin
					x_q   <= {quo_q[62:0], div_ge};
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			ST_SQRT: begin
				if (sq_ge) x_q <= x_q - sq_sum;
				res_q  <= res_nx;
				bit_q  <= bit_q >> 2;
				dist_q <= res_nx[31:0];
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign distance     = dist_q;
	assign zero_divisor = flag_q;

endmodule

// ===== hw/rtl/point_triangle_distance_top.sv =====
// Top level of the point to triangle distance block: register port, front, queue, back.
// Depends on ptd_pkg, ptd_front, ptd_queue, ptd_mul and ptd_back.
//
//   channel   signals                                   handshake
//   config    psel penable pwrite paddr pwdata prdata   APB, pready tied high, 64-bit words
//   query     query_x query_y query_z                   start while busy low
//   result    distance zero_divisor                     done strobe, one cycle
//
// The front takes a point in every cycle until the queue of QUEUE_DEPTH entries is full.
// The back works on one point at a time: 24 products at a vertex, 26 on an edge and 34 inside,
// all on the shared serial multiplier, then a 64-step divider and a 32-step root; a degenerate
// or saturated case skips those last two.
// Reset clears the triangle registers and empties the queue; results cannot be held off.
module point_triangle_distance_top #(
	parameter int COORD_WIDTH = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] query_x,
	input  logic [31:0] query_y,
	input  logic [31:0] query_z,
	output logic        done,
	output logic [31:0] distance,
	output logic        zero_divisor
);
	import ptd_pkg::*;

	localparam logic [2:0] REG_W0 = 3'd0;
	localparam logic [2:0] REG_W1 = 3'd1;
	localparam logic [2:0] REG_W2 = 3'd2;
	localparam logic [2:0] REG_W3 = 3'd3;
	localparam logic [2:0] REG_W4 = 3'd4;

	logic [63:0] w0_q, w1_q, w2_q, w3_q;
	logic [31:0] w4_q;
	logic [2:0]  idx;
	logic        wr_en;

	vtx_t     vtx;
	qstat_t   qst;
	dvec_t    wdata, head;
	logic     push, pop;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
			w3_q <= '0;
			w4_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_W0:  w0_q <= pwdata;
				REG_W1:  w1_q <= pwdata;
				REG_W2:  w2_q <= pwdata;
				REG_W3:  w3_q <= pwdata;
				REG_W4:  w4_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_W0:  prdata = w0_q;
			REG_W1:  prdata = w1_q;
			REG_W2:  prdata = w2_q;
			REG_W3:  prdata = w3_q;
			REG_W4:  prdata = {32'd0, w4_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		vtx.v0.x = ptd_coord(w0_q[31:0], COORD_WIDTH);
		vtx.v0.y = ptd_coord(w0_q[63:32], COORD_WIDTH);
		vtx.v0.z = ptd_coord(w1_q[31:0], COORD_WIDTH);
		vtx.v1.x = ptd_coord(w1_q[63:32], COORD_WIDTH);
		vtx.v1.y = ptd_coord(w2_q[31:0], COORD_WIDTH);
		vtx.v1.z = ptd_coord(w2_q[63:32], COORD_WIDTH);
		vtx.v2.x = ptd_coord(w3_q[31:0], COORD_WIDTH);
		vtx.v2.y = ptd_coord(w3_q[63:32], COORD_WIDTH);
		vtx.v2.z = ptd_coord(w4_q, COORD_WIDTH);
	end

	ptd_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.start   (start),
		.busy    (busy),
		.query_x (query_x),
		.query_y (query_y),
		.query_z (query_z),
		.v0      (vtx.v0),
		.qst     (qst),
		.push    (push),
		.wdata   (wdata)
	);

	ptd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.head   (head),
		.qst    (qst)
	);

	ptd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	ptd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vtx          (vtx),
		.head         (head),
		.qst          (qst),
		.pop          (pop),
		.mreq         (mreq),
		.mrsp         (mrsp),
		.done         (done),
		.distance     (distance),
		.zero_divisor (zero_divisor)
	);

endmodule
